// ===== rtl/point_triangle_sq_distance_assert.svh =====
// Assertion macros for the point-to-triangle distance pipeline.
// Used by point_triangle_sq_distance.sv; needs no other file.
`ifndef POINT_TRIANGLE_SQ_DISTANCE_ASSERT_SVH
`define POINT_TRIANGLE_SQ_DISTANCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ptsd_pkg.sv =====
// Shared types, widths and constants of the point-to-triangle distance pipeline.
// Depends on nothing; used by ptsd_div_pipe and point_triangle_sq_distance.
`default_nettype none

package ptsd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int IN_W       = 16;
  localparam int Q_BITS     = 16;

  localparam int VEC_W  = COORD_BITS + 1;
  localparam int DOT_W  = 2 * VEC_W + 2;
  localparam int LO_W   = DOT_W / 2;
  localparam int HI_W   = DOT_W - LO_W;
  localparam int PROD_W = 2 * DOT_W;
  localparam int WIDE_W = PROD_W + 4;
  localparam int EXT_W  = DOT_W + 2;

  localparam int PAR_W  = Q_BITS + 1;
  localparam int DIST_W = 34;

  localparam logic [PAR_W-1:0]  ONE_Q    = PAR_W'(1) << Q_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = 34'd12884901888;

  typedef logic [2:0][VEC_W-1:0] vec3_t;

  typedef struct packed {
    vec3_t e0;
    vec3_t e1;
    vec3_t d;
  } geom_t;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_ONE,
    SEL_Q0,
    SEL_Q1,
    SEL_CMP
  } sel_t;

  typedef struct packed {
    sel_t s_sel;
    sel_t t_sel;
    logic deg;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    geom_t geom;
  } side_t;

  typedef struct packed {
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] a_y;
    logic signed [IN_W-1:0] a_z;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] b_y;
    logic signed [IN_W-1:0] b_z;
    logic signed [IN_W-1:0] c_x;
    logic signed [IN_W-1:0] c_y;
    logic signed [IN_W-1:0] c_z;
    logic signed [IN_W-1:0] q_x;
    logic signed [IN_W-1:0] q_y;
    logic signed [IN_W-1:0] q_z;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] sq_distance;
    logic [PAR_W-1:0]  param_s;
    logic [PAR_W-1:0]  param_t;
    logic              degenerate;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/point_triangle_sq_distance.sv =====
// Throughput: one item per cycle; every stage advances together unless a
// result sits on the output while out_stall is high.
// The two quotient pipelines make up most of the pipeline's length.
// Reset clears the stage valid bits only; the data registers are not reset.
// Depends on ptsd_pkg, ptsd_div_pipe and point_triangle_sq_distance_assert.svh.
`default_nettype none

`include "point_triangle_sq_distance_assert.svh"

module point_triangle_sq_distance import ptsd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_item,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_item
);

  localparam int NSTG  = 9 + PAR_W;
  localparam int IA    = 0;
  localparam int IB    = 1;
  localparam int IC    = 2;
  localparam int ID    = 3;
  localparam int IE    = 4;
  localparam int PE_W  = VEC_W + PAR_W + 1;
  localparam int SUM_W = VEC_W + Q_BITS + 4;
  localparam int H_W   = SUM_W - FRAC_BITS;
  localparam int ACC_W = 2 * H_W + 2;
  localparam int SH_W  = ACC_W - Q_BITS;

  logic            adv;
  logic [NSTG-1:0] v_r;

  assign adv       = !(v_r[NSTG-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // Stage 1: edge vectors and the offset from the query point.
  logic signed [COORD_BITS-1:0] pa [3];
  logic signed [COORD_BITS-1:0] pb [3];
  logic signed [COORD_BITS-1:0] pc [3];
  logic signed [COORD_BITS-1:0] pq [3];
  geom_t                        g_in;
  geom_t                        geom_r [5];

  assign pa[0] = $signed(in_item.a_x[COORD_BITS-1:0]);
  assign pa[1] = $signed(in_item.a_y[COORD_BITS-1:0]);
  assign pa[2] = $signed(in_item.a_z[COORD_BITS-1:0]);
  assign pb[0] = $signed(in_item.b_x[COORD_BITS-1:0]);
  assign pb[1] = $signed(in_item.b_y[COORD_BITS-1:0]);
  assign pb[2] = $signed(in_item.b_z[COORD_BITS-1:0]);
  assign pc[0] = $signed(in_item.c_x[COORD_BITS-1:0]);
  assign pc[1] = $signed(in_item.c_y[COORD_BITS-1:0]);
  assign pc[2] = $signed(in_item.c_z[COORD_BITS-1:0]);
  assign pq[0] = $signed(in_item.q_x[COORD_BITS-1:0]);
  assign pq[1] = $signed(in_item.q_y[COORD_BITS-1:0]);
  assign pq[2] = $signed(in_item.q_z[COORD_BITS-1:0]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_in.e0[k] = VEC_W'(pb[k]) - VEC_W'(pa[k]);
      g_in.e1[k] = VEC_W'(pc[k]) - VEC_W'(pa[k]);
      g_in.d[k]  = VEC_W'(pa[k]) - VEC_W'(pq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geom_r[0] <= g_in;
      for (int i = 1; i < 5; i++) begin
        geom_r[i] <= geom_r[i-1];
      end
    end
  end

  // Stage 2: the dot products a to e.
  function automatic logic signed [DOT_W-1:0] dot3(vec3_t x, vec3_t y);
    logic signed [DOT_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = acc + DOT_W'($signed(x[k])) * DOT_W'($signed(y[k]));
    end
    return acc;
  endfunction

  logic signed [DOT_W-1:0] dots2_r [5];
  logic signed [DOT_W-1:0] dots3_r [5];
  logic signed [DOT_W-1:0] dots4_r [5];

  always_ff @(posedge clk) begin
    if (adv) begin
      dots2_r[IA] <= dot3(geom_r[0].e0, geom_r[0].e0);
      dots2_r[IB] <= dot3(geom_r[0].e0, geom_r[0].e1);
      dots2_r[IC] <= dot3(geom_r[0].e1, geom_r[0].e1);
      dots2_r[ID] <= dot3(geom_r[0].e0, geom_r[0].d);
      dots2_r[IE] <= dot3(geom_r[0].e1, geom_r[0].d);
      dots3_r     <= dots2_r;
      dots4_r     <= dots3_r;
    end
  end

  // Stage 3: each wide product is split into two partial products on the
  // low and high halves of its second operand.
  logic signed [DOT_W-1:0]      mx [6];
  logic signed [DOT_W-1:0]      my [6];
  logic signed [DOT_W+LO_W:0]   plo_r [6];
  logic signed [DOT_W+HI_W-1:0] phi_r [6];

  assign mx[0] = dots2_r[IB];
  assign my[0] = dots2_r[IE];
  assign mx[1] = dots2_r[IC];
  assign my[1] = dots2_r[ID];
  assign mx[2] = dots2_r[IB];
  assign my[2] = dots2_r[ID];
  assign mx[3] = dots2_r[IA];
  assign my[3] = dots2_r[IE];
  assign mx[4] = dots2_r[IA];
  assign my[4] = dots2_r[IC];
  assign mx[5] = dots2_r[IB];
  assign my[5] = dots2_r[IB];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        plo_r[k] <= mx[k] * $signed({1'b0, my[k][LO_W-1:0]});
        phi_r[k] <= mx[k] * $signed(my[k][DOT_W-1:LO_W]);
      end
    end
  end

  // Stage 4: the region numerators s', t' and the determinant.
  logic signed [WIDE_W-1:0] prod [6];
  logic signed [WIDE_W-1:0] sn_r;
  logic signed [WIDE_W-1:0] tn_r;
  logic signed [WIDE_W-1:0] det_r;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      prod[k] = (WIDE_W'(phi_r[k]) <<< LO_W) + WIDE_W'(plo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_r  <= prod[0] - prod[1];
      tn_r  <= prod[2] - prod[3];
      det_r <= prod[4] - prod[5];
    end
  end

  // Stage 5: region choice and the operands of both quotients.
  logic signed [EXT_W-1:0]  ea, eb, ec, ed, ee, ned, nee, denom;
  logic signed [EXT_W-1:0]  tmp0, tmp1, numer;
  logic signed [WIDE_W:0]   st_sum;
  logic                     in_tri;
  logic signed [WIDE_W-1:0] n0, d0, n1, d1;
  ctrl_t                    ctrl5;
  logic [WIDE_W-1:0]        n0_r, d0_r, n1_r, d1_r;
  ctrl_t                    ctrl5_r;

  always_comb begin
    ea     = EXT_W'(dots4_r[IA]);
    eb     = EXT_W'(dots4_r[IB]);
    ec     = EXT_W'(dots4_r[IC]);
    ed     = EXT_W'(dots4_r[ID]);
    ee     = EXT_W'(dots4_r[IE]);
    ned    = -ed;
    nee    = -ee;
    denom  = ea - (eb <<< 1) + ec;
    st_sum = (WIDE_W+1)'(sn_r) + (WIDE_W+1)'(tn_r);
    in_tri = ((WIDE_W+1)'(det_r) >= st_sum);
    tmp0   = '0;
    tmp1   = '0;
    numer  = '0;
    n0     = '0;
    d0     = '0;
    n1     = '0;
    d1     = '0;
    ctrl5.s_sel = SEL_ZERO;
    ctrl5.t_sel = SEL_ZERO;
    ctrl5.deg   = 1'b0;

    if (in_tri) begin
      if (sn_r < 0 && !(tn_r < 0 && ed < 0)) begin
        // Clamp to edge e1.
        if (ee >= 0) begin
          ctrl5.t_sel = SEL_ZERO;
        end else if (nee >= ec) begin
          ctrl5.t_sel = SEL_ONE;
        end else begin
          ctrl5.t_sel = SEL_Q0;
          n0 = WIDE_W'(nee);
          d0 = WIDE_W'(ec);
        end
      end else if (sn_r < 0 || tn_r < 0) begin
        // Clamp to edge e0.
        if (ed >= 0) begin
          ctrl5.s_sel = SEL_ZERO;
        end else if (ned >= ea) begin
          ctrl5.s_sel = SEL_ONE;
        end else begin
          ctrl5.s_sel = SEL_Q0;
          n0 = WIDE_W'(ned);
          d0 = WIDE_W'(ea);
        end
      end else if (det_r == '0) begin
        ctrl5.deg = 1'b1;
      end else begin
        ctrl5.s_sel = SEL_Q0;
        ctrl5.t_sel = SEL_Q1;
        n0 = sn_r;
        d0 = det_r;
        n1 = tn_r;
        d1 = det_r;
      end
    end else if (sn_r < 0) begin
      tmp1 = ec + ee;
      tmp0 = eb + ed;
      numer = tmp1 - tmp0;
      if (tmp1 > tmp0) begin
        if (numer >= denom) begin
          ctrl5.s_sel = SEL_ONE;
        end else begin
          ctrl5.s_sel = SEL_Q0;
          ctrl5.t_sel = SEL_CMP;
          n0 = WIDE_W'(numer);
          d0 = WIDE_W'(denom);
        end
      end else if (tmp1 <= 0) begin
        ctrl5.t_sel = SEL_ONE;
      end else if (ee < 0) begin
        ctrl5.t_sel = SEL_Q0;
        n0 = WIDE_W'(nee);
        d0 = WIDE_W'(ec);
      end
    end else if (tn_r < 0) begin
      tmp1 = ea + ed;
      tmp0 = eb + ee;
      numer = tmp1 - tmp0;
      if (tmp1 > tmp0) begin
        if (numer >= denom) begin
          ctrl5.t_sel = SEL_ONE;
        end else begin
          ctrl5.t_sel = SEL_Q0;
          ctrl5.s_sel = SEL_CMP;
          n0 = WIDE_W'(numer);
          d0 = WIDE_W'(denom);
        end
      end else if (tmp1 <= 0) begin
        ctrl5.s_sel = SEL_ONE;
      end else if (ed < 0) begin
        ctrl5.s_sel = SEL_Q0;
        n0 = WIDE_W'(ned);
        d0 = WIDE_W'(ea);
      end
    end else begin
      numer = ec + ee - eb - ed;
      if (numer <= 0) begin
        ctrl5.t_sel = SEL_ONE;
      end else if (numer >= denom) begin
        ctrl5.s_sel = SEL_ONE;
      end else begin
        ctrl5.s_sel = SEL_Q0;
        ctrl5.t_sel = SEL_CMP;
        n0 = WIDE_W'(numer);
        d0 = WIDE_W'(denom);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n0_r    <= n0;
      d0_r    <= d0;
      n1_r    <= n1;
      d1_r    <= d1;
      ctrl5_r <= ctrl5;
    end
  end

  // Stages 6 to 22: both quotients, with the item's side data alongside.
  logic [PAR_W-1:0] q0, q1;
  side_t            side_r [PAR_W];

  ptsd_div_pipe #(.W(WIDE_W), .QB(PAR_W)) u_div0 (
    .clk (clk),
    .en  (adv),
    .num (n0_r),
    .den (d0_r),
    .quo (q0)
  );

  ptsd_div_pipe #(.W(WIDE_W), .QB(PAR_W)) u_div1 (
    .clk (clk),
    .en  (adv),
    .num (n1_r),
    .den (d1_r),
    .quo (q1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{ctrl: ctrl5_r, geom: geom_r[4]};
      for (int i = 1; i < PAR_W; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Stage 23: pick s and t and weight the edge vectors.
  function automatic logic [PAR_W-1:0] pick(sel_t sel, logic [PAR_W-1:0] qa,
                                            logic [PAR_W-1:0] qb);
    logic [PAR_W-1:0] v;
    case (sel)
      SEL_ONE: v = ONE_Q;
      SEL_Q0:  v = qa;
      SEL_Q1:  v = qb;
      SEL_CMP: v = ONE_Q - qa;
      default: v = '0;
    endcase
    return v;
  endfunction

  side_t                   tail;
  logic [PAR_W-1:0]        s23, t23;
  logic [PAR_W-1:0]        s23_r, t23_r, s24_r, t24_r, s25_r, t25_r;
  logic                    deg23_r, deg24_r, deg25_r;
  logic signed [PE_W-1:0]  pe0_r [3];
  logic signed [PE_W-1:0]  pe1_r [3];
  vec3_t                   d23_r;

  assign tail = side_r[PAR_W-1];
  assign s23  = tail.ctrl.deg ? '0 : pick(tail.ctrl.s_sel, q0, q1);
  assign t23  = tail.ctrl.deg ? '0 : pick(tail.ctrl.t_sel, q0, q1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s23_r   <= s23;
      t23_r   <= t23;
      deg23_r <= tail.ctrl.deg;
      d23_r   <= tail.geom.d;
      for (int k = 0; k < 3; k++) begin
        pe0_r[k] <= $signed({1'b0, s23}) * $signed(tail.geom.e0[k]);
        pe1_r[k] <= $signed({1'b0, t23}) * $signed(tail.geom.e1[k]);
      end
    end
  end

  // Stage 24: per-axis offset of the closest point, floored to Q.8.
  logic signed [SUM_W-1:0] hsum [3];
  logic signed [H_W-1:0]   h_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hsum[k] = (SUM_W'($signed(d23_r[k])) <<< Q_BITS) + SUM_W'(pe0_r[k])
              + SUM_W'(pe1_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s24_r   <= s23_r;
      t24_r   <= t23_r;
      deg24_r <= deg23_r;
      for (int k = 0; k < 3; k++) begin
        h_r[k] <= $signed(hsum[k][SUM_W-1:FRAC_BITS]);
      end
    end
  end

  // Stage 25: squares.
  logic signed [2*H_W-1:0] hsq_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s25_r   <= s24_r;
      t25_r   <= t24_r;
      deg25_r <= deg24_r;
      for (int k = 0; k < 3; k++) begin
        hsq_r[k] <= h_r[k] * h_r[k];
      end
    end
  end

  // Stage 26: sum, rescale and saturate into the output register.
  logic [ACC_W-1:0] acc;
  logic [SH_W-1:0]  dist_sh;
  out_item_t        out_r;

  assign acc = ACC_W'($unsigned(hsq_r[0])) + ACC_W'($unsigned(hsq_r[1]))
             + ACC_W'($unsigned(hsq_r[2]));
  assign dist_sh = acc[ACC_W-1:Q_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.sq_distance <= (dist_sh > SH_W'(DIST_MAX)) ? DIST_MAX
                                                        : dist_sh[DIST_W-1:0];
      out_r.param_s     <= s25_r;
      out_r.param_t     <= t25_r;
      out_r.degenerate  <= deg25_r;
    end
  end

  assign out_item = out_r;

  `PTSD_ASSERT_NOW(a_deg_zero, clk, rst_n, out_valid && out_item.degenerate, (out_item.param_s == '0) && (out_item.param_t == '0), "degenerate item with nonzero parameters")
  `PTSD_ASSERT_NOW(a_st_sum, clk, rst_n, out_valid, ((PAR_W+1)'(out_item.param_s) + (PAR_W+1)'(out_item.param_t)) <= (PAR_W+1)'(ONE_Q), "s plus t exceeds one")
  `PTSD_ASSERT_NOW(a_dist_max, clk, rst_n, out_valid, out_item.sq_distance <= DIST_MAX, "distance above saturation limit")
  `PTSD_ASSERT_NEXT(a_last_adv, clk, rst_n, v_r[NSTG-2] && adv, out_valid, "item lost before the output register")

endmodule

`default_nettype wire

// ===== rtl/ptsd_div_pipe.sv =====
// Pipelined restoring divider giving floor(num * 2^(QB-1) / den) for num <= den.
// One quotient bit per stage; depends on ptsd_pkg for default widths.
`default_nettype none

module ptsd_div_pipe import ptsd_pkg::*; #(
  parameter int W  = WIDE_W,
  parameter int QB = PAR_W
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [W-1:0]  num,
  input  wire logic [W-1:0]  den,
  output      logic [QB-1:0] quo
);

  logic [W-1:0]  rem_r [QB-1];
  logic [W-1:0]  den_r [QB-1];
  logic [QB-1:0] quo_r [QB];
  logic          ge0;

  // The first step decides the integer bit, which is set only when num equals den.
  assign ge0 = (num >= den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ge0 ? (num - den) : num;
      den_r[0] <= den;
      quo_r[0] <= QB'(ge0);
    end
  end

  for (genvar j = 1; j < QB; j++) begin : g_step
    logic [W:0] sh;
    logic       ge;

    assign sh = {rem_r[j-1], 1'b0};
    assign ge = (sh >= {1'b0, den_r[j-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= {quo_r[j-1][QB-2:0], ge};
      end
    end

    if (j < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? W'(sh - {1'b0, den_r[j-1]}) : sh[W-1:0];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

`default_nettype wire
